>>> src/bmq_pkg.sv
// Shared constants, codes and controller/datapath interface types for the message queue.
`timescale 1ns / 1ps

package bmq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int MAX_BYTES     = 64;
  localparam int COUNTER_WIDTH = 32;

  localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
  localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W     = 7;
  localparam int PAY_DEPTH = QUEUE_DEPTH * MAX_BYTES;
  localparam int PAY_AW    = $clog2(PAY_DEPTH);

  localparam logic [LEN_W-1:0] BYTES_SAT = 7'd127;

  localparam logic [1:0] OP_SEND  = 2'd0;
  localparam logic [1:0] OP_RECV  = 2'd1;
  localparam logic [1:0] OP_COUNT = 2'd2;

  localparam logic [1:0] SEL_SENT    = 2'd0;
  localparam logic [1:0] SEL_RECV    = 2'd1;
  localparam logic [1:0] SEL_DROPPED = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DROPPED   = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_TOO_SMALL = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic send;
    logic recv;
    logic count;
    logic stream_step;
  } bmq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rx_stream;
    logic stream_last;
  } bmq_sts_t;

endpackage

>>> src/bmq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module bmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/bmq_ctrl.sv
// Controller state machine: decodes commands and sequences the byte stream of a receive.
`timescale 1ns / 1ps

module bmq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        opcode,
  input  bmq_pkg::bmq_sts_t sts,
  output bmq_pkg::bmq_cmd_t cmd,
  output logic              busy
);

  import bmq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_STREAM
  } state_t;

  state_t state, state_next;
  logic   busy_next;
  logic   accept;

  assign accept = start && !busy;

  always_comb begin
    cmd.send        = accept && (opcode == OP_SEND);
    cmd.recv        = accept && (opcode == OP_RECV);
    cmd.count       = accept && (opcode == OP_COUNT);
    cmd.stream_step = (state == S_STREAM);
  end

  always_comb begin
    state_next = state;
    busy_next  = busy;
    unique case (state)
      S_IDLE: begin
        if (cmd.recv && sts.rx_stream) begin
          state_next = S_STREAM;
          busy_next  = 1'b1;
        end
      end
      S_STREAM: begin
        if (sts.stream_last) begin
          state_next = S_IDLE;
          busy_next  = 1'b0;
        end
      end
      default: begin
        state_next = S_IDLE;
        busy_next  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= busy_next;
    end
  end

endmodule

>>> src/bmq_datapath.sv
// Datapath: ring indices, payload and length stores, statistics counters and result registers.
`timescale 1ns / 1ps

module bmq_datapath (
  input  logic              clk,
  input  logic              rst,
  input  bmq_pkg::bmq_cmd_t cmd,
  output bmq_pkg::bmq_sts_t sts,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              no_payload,
  input  logic              drop_on_full,
  input  logic [6:0]        dest_capacity,
  input  logic [1:0]        counter_select,
  output logic              done,
  output logic [2:0]        status,
  output logic [7:0]        out_byte,
  output logic              byte_valid,
  output logic              out_last,
  output logic [6:0]        msg_length,
  output logic [31:0]       counter_value
);

  import bmq_pkg::*;

  typedef enum logic [1:0] {
    M_IDLE,
    M_STORE,
    M_BLOCKED
  } mode_t;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BYTES);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);

  logic [SLOT_W-1:0]        read_index, write_index, base_slot;
  logic [OCC_W-1:0]         occupied_count;
  logic [LEN_W-1:0]         bytes_written, max_len, rx_len, rd_pos;
  mode_t                    incoming_mode;
  logic [COUNTER_WIDTH-1:0] sent_total, received_total, dropped_total;
  logic [LEN_W-1:0]         length_store [QUEUE_DEPTH];

  logic [2:0]  status_r;
  logic [6:0]  len_r;
  logic [31:0] cnt_r;
  logic        last_r, bvalid_r, strobe_r;

  mode_t              mode_eff;
  logic [LEN_W-1:0]   bw_eff, bw_new, limit, len_raw, rx_len_c;
  logic               ends, pay_we, empty, fits;
  logic [PAY_AW-1:0]  waddr, raddr;
  logic [7:0]         rdata;
  logic [COUNTER_WIDTH-1:0] cnt_sel;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] i);
    return (i == LAST_SLOT) ? '0 : i + SLOT_W'(1);
  endfunction

  function automatic logic [COUNTER_WIDTH-1:0] sat_inc(input logic [COUNTER_WIDTH-1:0] c);
    return (c == '1) ? c : c + COUNTER_WIDTH'(1);
  endfunction

  // Send path: the first item of a message claims the tail slot or finds the queue full.
  always_comb begin
    if (incoming_mode == M_IDLE) begin
      mode_eff = (occupied_count >= OCC_W'(QUEUE_DEPTH)) ? M_BLOCKED : M_STORE;
      bw_eff   = '0;
    end else begin
      mode_eff = incoming_mode;
      bw_eff   = bytes_written;
    end
    ends   = no_payload || in_last;
    pay_we = cmd.send && !no_payload && (mode_eff == M_STORE) && (bw_eff < MAX_LEN);
    bw_new = (!no_payload && (bw_eff < BYTES_SAT)) ? bw_eff + LEN_W'(1) : bw_eff;
    limit  = (max_len < MAX_LEN) ? max_len : MAX_LEN;
    waddr  = PAY_AW'(PAY_AW'(write_index) * PAY_AW'(MAX_BYTES)) + PAY_AW'(bw_eff);
  end

  // Receive path: head slot length, clipped to the slot size.
  always_comb begin
    len_raw  = length_store[read_index];
    rx_len_c = (len_raw > MAX_LEN) ? MAX_LEN : len_raw;
    empty    = (occupied_count == '0);
    fits     = (rx_len_c <= dest_capacity);
    sts.rx_stream   = !empty && fits && (rx_len_c != '0);
    sts.stream_last = (rd_pos + LEN_W'(1) == rx_len);
    raddr = PAY_AW'(PAY_AW'(base_slot) * PAY_AW'(MAX_BYTES)) + PAY_AW'(rd_pos);
  end

  always_comb begin
    case (counter_select)
      SEL_SENT:    cnt_sel = sent_total;
      SEL_RECV:    cnt_sel = received_total;
      SEL_DROPPED: cnt_sel = dropped_total;
      default:     cnt_sel = '0;
    endcase
  end

  bmq_ram #(
    .WIDTH(8),
    .DEPTH(PAY_DEPTH)
  ) u_payload (
    .clk  (clk),
    .we   (pay_we),
    .waddr(waddr),
    .wdata(in_byte),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.send && ends && (bw_new <= limit) && (mode_eff == M_STORE)) begin
      length_store[write_index] <= bw_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_index     <= '0;
      write_index    <= '0;
      occupied_count <= '0;
      bytes_written  <= '0;
      incoming_mode  <= M_IDLE;
      sent_total     <= '0;
      received_total <= '0;
      dropped_total  <= '0;
      max_len        <= MAX_LEN;
      strobe_r       <= 1'b0;
      bvalid_r       <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      bvalid_r <= 1'b0;
      if (cfg_we) begin
        max_len <= cfg_wdata;
      end

      if (cmd.send) begin
        if (ends) begin
          strobe_r      <= 1'b1;
          incoming_mode <= M_IDLE;
          bytes_written <= '0;
          if (bw_new > limit) begin
            status_r <= ST_TOO_LARGE;
            len_r    <= '0;
          end else if (mode_eff == M_BLOCKED) begin
            len_r <= '0;
            if (drop_on_full) begin
              status_r      <= ST_DROPPED;
              dropped_total <= sat_inc(dropped_total);
            end else begin
              status_r <= ST_FULL;
            end
          end else begin
            status_r       <= ST_OK;
            len_r          <= bw_new;
            write_index    <= next_slot(write_index);
            occupied_count <= occupied_count + OCC_W'(1);
            sent_total     <= sat_inc(sent_total);
          end
          last_r <= 1'b1;
          cnt_r  <= '0;
        end else begin
          incoming_mode <= mode_eff;
          bytes_written <= bw_new;
        end
      end

      if (cmd.recv) begin
        if (empty) begin
          strobe_r <= 1'b1;
          status_r <= ST_EMPTY;
          len_r    <= '0;
        end else begin
          read_index     <= next_slot(read_index);
          occupied_count <= occupied_count - OCC_W'(1);
          base_slot      <= read_index;
          rx_len         <= rx_len_c;
          rd_pos         <= '0;
          if (!fits) begin
            strobe_r      <= 1'b1;
            status_r      <= ST_TOO_SMALL;
            len_r         <= rx_len_c;
            dropped_total <= sat_inc(dropped_total);
          end else begin
            received_total <= sat_inc(received_total);
            if (rx_len_c == '0) begin
              strobe_r <= 1'b1;
              status_r <= ST_OK;
              len_r    <= '0;
            end
          end
        end
        last_r <= 1'b1;
        cnt_r  <= '0;
      end

      if (cmd.count) begin
        strobe_r <= 1'b1;
        status_r <= ST_OK;
        len_r    <= '0;
        last_r   <= 1'b1;
        cnt_r    <= 32'(cnt_sel);
      end

      if (cmd.stream_step) begin
        strobe_r <= 1'b1;
        bvalid_r <= 1'b1;
        status_r <= ST_OK;
        len_r    <= rx_len;
        last_r   <= sts.stream_last;
        cnt_r    <= '0;
        rd_pos   <= rd_pos + LEN_W'(1);
      end
    end
  end

  assign done          = strobe_r;
  assign status        = status_r;
  assign out_byte      = bvalid_r ? rdata : 8'h00;
  assign byte_valid    = bvalid_r;
  assign out_last      = last_r;
  assign msg_length    = len_r;
  assign counter_value = cnt_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupied_count <= OCC_W'(QUEUE_DEPTH))
    else $error("occupied count beyond queue depth");

  a_stream_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.stream_step |-> !cmd.send && !cmd.recv && !cmd.count)
    else $error("new item accepted while a message is streaming");

  a_byte_strobed: assert property (@(posedge clk) disable iff (rst)
    bvalid_r |-> strobe_r)
    else $error("payload byte presented without a strobe");

  a_stream_in_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.stream_step |-> (rd_pos < rx_len) && (rx_len <= MAX_LEN))
    else $error("stream read beyond message length");

endmodule

>>> src/bounded_message_queue.sv
// Top level of the bounded message queue: controller and datapath.
`timescale 1ns / 1ps

// Channel      Direction  Handshake                     Payload
// command      in         start, taken when busy is low  opcode, in_byte, in_last, no_payload,
//                                                        drop_on_full, dest_capacity,
//                                                        counter_select
// result       out        done, one cycle, no stall      status, out_byte, byte_valid,
//                                                        out_last, msg_length, counter_value
// config       in         cfg_we, taken at once           cfg_wdata (max_message_len)
//
// A send byte or a counter read leaves busy low, so a new item may be given in every cycle,
// and the result of an ending item appears in the following cycle. A receive of a message
// of n bytes holds busy high while the payload RAM read port yields one byte a cycle; the
// bytes appear in the cycle after their reads. An empty, discarded or zero-length receive
// leaves busy low. Reset is synchronous and clears indices, counts and counters at once;
// the stores need no clearing, since only committed slots are read. The receiver cannot
// stall results.

module bounded_message_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic [1:0]  opcode,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  input  logic        no_payload,
  input  logic        drop_on_full,
  input  logic [6:0]  dest_capacity,
  input  logic [1:0]  counter_select,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        out_last,
  output logic [6:0]  msg_length,
  output logic [31:0] counter_value
);

  import bmq_pkg::*;

  // Commands flow from the controller, status back from the datapath.
  bmq_cmd_t cmd;
  bmq_sts_t sts;

  // The controller owns busy and the streaming sequence of a receive.
  bmq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .opcode(opcode),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the ring, the stores, the counters and the result registers.
  bmq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .no_payload    (no_payload),
    .drop_on_full  (drop_on_full),
    .dest_capacity (dest_capacity),
    .counter_select(counter_select),
    .done          (done),
    .status        (status),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .out_last      (out_last),
    .msg_length    (msg_length),
    .counter_value (counter_value)
  );

endmodule
